>>> rtl/dcmq_pkg.sv
// dcmq_pkg: shared types and constants for the DCM to quaternion block.
// No dependencies.
package dcmq_pkg;

  localparam int unsigned SQ_N  = 15;     // root digits, one per sqrt stage
  localparam int unsigned DV_N  = 16;     // quotient bits, one per divide stage
  localparam int unsigned Q_ONE = 16384;  // 1.0 in Q2.14

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } sel_t;

  // d[0..3] feed x, y, z, w; the winner's slot is unused
  typedef struct packed {
    sel_t             sel;
    logic [3:0][17:0] d;
  } pl_t;

  // one classified matrix in the queue between front and back
  typedef struct packed {
    logic [16:0] c;   // winning candidate, always in [16384, 114687]
    pl_t         pl;
  } fq_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } res_t;

endpackage

>>> rtl/dcm_to_quaternion.sv
// dcm_to_quaternion: top level, front classifier, back arithmetic pipeline
// and result queue. Depends on dcmq_pkg, dcmq_front, dcmq_back, dcmq_fifo.
//
// Usage:
//   Input side is a queue: drive in_m00..in_m22 (signed Q2.14) with push;
//   a beat is taken on a rising edge with push high and full low.
//   Result side is a queue: while empty is low, out_quat_x/y/z/w hold the
//   oldest result (signed Q2.14, saturated to +-1.0, scalar last); pop high
//   with empty low takes it.
//   Throughput: one matrix per cycle, sustained, with pop held high.
//   Path: 15 square-root digit stages, one rounding stage, 16 quotient-bit
//   divider stages, one saturation register and the write into the result
//   queue. The divider chain is the longest part of it.
//   Stall: when the result queue fills, the back pipeline freezes as a
//   whole; the input queue then fills, and full rises once it holds
//   IN_QUEUE_DEPTH beats. Nothing is dropped or repeated.
//   Reset: synchronous, active low; empties both queues and invalidates
//   every pipeline stage. Data registers are not reset.
module dcm_to_quaternion import dcmq_pkg::*; #(
  parameter int unsigned IN_QUEUE_DEPTH  = 4,
  parameter int unsigned OUT_QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_m00,
  input  logic signed [15:0] in_m01,
  input  logic signed [15:0] in_m02,
  input  logic signed [15:0] in_m10,
  input  logic signed [15:0] in_m11,
  input  logic signed [15:0] in_m12,
  input  logic signed [15:0] in_m20,
  input  logic signed [15:0] in_m21,
  input  logic signed [15:0] in_m22,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_quat_x,
  output logic signed [15:0] out_quat_y,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w
);

  logic fq_pop, fq_empty;
  fq_t  fq;
  logic bk_vld, oq_full;
  res_t bk_res, oq_res;
  logic [$bits(res_t)-1:0] oq_rd;

  // front: candidates, winner pick, operand sums, queued
  dcmq_front #(.DEPTH(IN_QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .m00      (in_m00), .m01 (in_m01), .m02 (in_m02),
    .m10      (in_m10), .m11 (in_m11), .m12 (in_m12),
    .m20      (in_m20), .m21 (in_m21), .m22 (in_m22),
    .fq_pop   (fq_pop),
    .fq_empty (fq_empty),
    .fq       (fq)
  );

  // back: root, rounding, divides, saturation
  dcmq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .fq_vld  (!fq_empty),
    .fq      (fq),
    .fq_pop  (fq_pop),
    .res_vld (bk_vld),
    .res     (bk_res),
    .res_rdy (!oq_full)
  );

  // result queue decouples the pipeline from the consumer
  dcmq_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_QUEUE_DEPTH)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_vld),
    .wdata (bk_res),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rd),
    .empty (empty)
  );

  assign oq_res     = res_t'(oq_rd);
  assign out_quat_x = oq_res.quat_x;
  assign out_quat_y = oq_res.quat_y;
  assign out_quat_z = oq_res.quat_z;
  assign out_quat_w = oq_res.quat_w;

  // every shown component lies in [-1.0, +1.0]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ($signed(out_quat_x) <= 16384 && $signed(out_quat_x) >= -16384 &&
                $signed(out_quat_y) <= 16384 && $signed(out_quat_y) >= -16384 &&
                $signed(out_quat_z) <= 16384 && $signed(out_quat_z) >= -16384 &&
                $signed(out_quat_w) <= 16384 && $signed(out_quat_w) >= -16384))
    else $error("quaternion component out of range");

  // winning component is a root of at least 0.5
  a_winner: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_quat_x >= 16'sd8192 || out_quat_y >= 16'sd8192 ||
                out_quat_z >= 16'sd8192 || out_quat_w >= 16'sd8192))
    else $error("no component carries the root");

  // reset leaves the result queue empty and the input queue not full
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

>>> rtl/dcmq_fifo.sv
// dcmq_fifo: small first-in first-out queue with a count-based full flag.
// No dependencies.
module dcmq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/dcmq_front.sv
// dcmq_front: forms the four candidates, picks the winner and the operand
// sums, and queues the result. Depends on dcmq_pkg and dcmq_fifo.
module dcmq_front import dcmq_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] m00, m01, m02,
  input  logic signed [15:0] m10, m11, m12,
  input  logic signed [15:0] m20, m21, m22,
  input  logic               fq_pop,
  output logic               fq_empty,
  output fq_t                fq
);

  logic signed [18:0] cx, cy, cz, cw, cwin;
  logic signed [17:0] s01, s02, s12, a12, a20, a01;
  fq_t                ent;
  logic [$bits(fq_t)-1:0] rd;

  always_comb begin
    cx = 19'(Q_ONE) + 19'(m00) - 19'(m11) - 19'(m22);
    cy = 19'(Q_ONE) - 19'(m00) + 19'(m11) - 19'(m22);
    cz = 19'(Q_ONE) - 19'(m00) - 19'(m11) + 19'(m22);
    cw = 19'(Q_ONE) + 19'(m00) + 19'(m11) + 19'(m22);
    s01 = 18'(m01) + 18'(m10);
    s02 = 18'(m20) + 18'(m02);
    s12 = 18'(m12) + 18'(m21);
    a12 = 18'(m12) - 18'(m21);
    a20 = 18'(m20) - 18'(m02);
    a01 = 18'(m01) - 18'(m10);
    ent = '0;
    // ties go to the earlier candidate
    if (cx >= cy && cx >= cz && cx >= cw) begin
      cwin      = cx;
      ent.pl.sel = SEL_X;
      ent.pl.d[1] = s01; ent.pl.d[2] = s02; ent.pl.d[3] = a12;
    end else if (cy >= cz && cy >= cw) begin
      cwin      = cy;
      ent.pl.sel = SEL_Y;
      ent.pl.d[0] = s01; ent.pl.d[2] = s12; ent.pl.d[3] = a20;
    end else if (cz >= cw) begin
      cwin      = cz;
      ent.pl.sel = SEL_Z;
      ent.pl.d[0] = s02; ent.pl.d[1] = s12; ent.pl.d[3] = a01;
    end else begin
      cwin      = cw;
      ent.pl.sel = SEL_W;
      ent.pl.d[0] = a12; ent.pl.d[1] = a20; ent.pl.d[2] = a01;
    end
    ent.c = cwin[16:0];
  end

  dcmq_fifo #(.WIDTH($bits(fq_t)), .DEPTH(DEPTH)) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (ent),
    .full  (full),
    .pop   (fq_pop),
    .rdata (rd),
    .empty (fq_empty)
  );

  assign fq = fq_t'(rd);

endmodule

>>> rtl/dcmq_back.sv
// dcmq_back: pipelined square root, rounding, four restoring dividers and
// saturation. Depends on dcmq_pkg.
module dcmq_back import dcmq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fq_vld,
  input  fq_t  fq,
  output logic fq_pop,
  output logic res_vld,
  output res_t res,
  input  logic res_rdy
);

  typedef struct packed {
    logic [17:0] rem;
    logic [14:0] root;
    logic [29:0] xs;
    pl_t         pl;
  } sq_t;

  typedef struct packed {
    logic [14:0] r;
    pl_t         pl;
  } rd_t;

  typedef struct packed {
    logic [3:0][14:0] rem;
    logic [3:0][15:0] lo;
    logic [3:0][15:0] q;
    logic [14:0]      r;
    pl_t              pl;
  } dv_t;

  function automatic sq_t sq_step(sq_t s);
    logic [17:0] sh, tr;
    sh = {s.rem[15:0], s.xs[29:28]};
    tr = {1'b0, s.root, 2'b01};
    sq_step    = s;
    sq_step.xs = {s.xs[27:0], 2'b00};
    if (sh >= tr) begin
      sq_step.rem  = sh - tr;
      sq_step.root = {s.root[13:0], 1'b1};
    end else begin
      sq_step.rem  = sh;
      sq_step.root = {s.root[13:0], 1'b0};
    end
  endfunction

  function automatic dv_t dv_step(dv_t s);
    logic [15:0] t;
    dv_step = s;
    for (int i = 0; i < 4; i++) begin
      t = {s.rem[i], s.lo[i][15]};
      dv_step.lo[i] = {s.lo[i][14:0], 1'b0};
      if (t >= {1'b0, s.r}) begin
        dv_step.rem[i] = 15'(t - {1'b0, s.r});
        dv_step.q[i]   = {s.q[i][14:0], 1'b1};
      end else begin
        dv_step.rem[i] = t[14:0];
        dv_step.q[i]   = {s.q[i][14:0], 1'b0};
      end
    end
  endfunction

  logic adv;
  logic sq_v_r [SQ_N];
  sq_t  sq_r   [SQ_N];
  sq_t  sq_nxt [SQ_N];
  logic rd_v_r;
  rd_t  rd_r, rd_nxt;
  logic dv_v_r [DV_N];
  dv_t  dv_r   [DV_N];
  dv_t  dv_nxt [DV_N];
  logic out_v_r;
  res_t out_r, out_nxt;

  assign adv     = !out_v_r || res_rdy;
  assign fq_pop  = adv && fq_vld;
  assign res_vld = out_v_r;
  assign res     = out_r;

  always_comb begin
    sq_t s0;
    s0.rem  = '0;
    s0.root = '0;
    s0.xs   = {1'b0, fq.c, 12'b0};
    s0.pl   = fq.pl;
    sq_nxt[0] = sq_step(s0);
    for (int k = 1; k < SQ_N; k++) begin
      sq_nxt[k] = sq_step(sq_r[k-1]);
    end
  end

  // round to nearest: remainder above the root means past the half point
  always_comb begin
    rd_nxt.pl = sq_r[SQ_N-1].pl;
    rd_nxt.r  = sq_r[SQ_N-1].root +
                15'(sq_r[SQ_N-1].rem > {3'b0, sq_r[SQ_N-1].root});
  end

  always_comb begin
    dv_t              d0;
    logic [17:0]      ng;
    logic [16:0]      mag;
    logic [28:0]      n;
    d0.r  = rd_r.r;
    d0.pl = rd_r.pl;
    d0.q  = '0;
    d0.rem = '0;
    d0.lo  = '0;
    for (int i = 0; i < 4; i++) begin
      ng  = -rd_r.pl.d[i];
      mag = rd_r.pl.d[i][17] ? ng[16:0] : rd_r.pl.d[i][16:0];
      n   = 29'({mag, 12'b0}) + 29'(rd_r.r[14:1]);
      d0.rem[i] = {2'b00, n[28:16]};
      d0.lo[i]  = n[15:0];
    end
    dv_nxt[0] = dv_step(d0);
    for (int k = 1; k < DV_N; k++) begin
      dv_nxt[k] = dv_step(dv_r[k-1]);
    end
  end

  always_comb begin
    logic [3:0][15:0] v;
    logic [15:0]      qc;
    logic [14:0]      rc;
    dv_t              s;
    s  = dv_r[DV_N-1];
    rc = (s.r > 15'(Q_ONE)) ? 15'(Q_ONE) : s.r;
    for (int i = 0; i < 4; i++) begin
      qc = (s.q[i] > 16'(Q_ONE)) ? 16'(Q_ONE) : s.q[i];
      v[i] = s.pl.d[i][17] ? -qc : qc;
      if (s.pl.sel == sel_t'(i)) begin
        v[i] = {1'b0, rc};
      end
    end
    out_nxt.quat_x = v[0];
    out_nxt.quat_y = v[1];
    out_nxt.quat_z = v[2];
    out_nxt.quat_w = v[3];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQ_N; k++) sq_r[k] <= sq_nxt[k];
      rd_r <= rd_nxt;
      for (int k = 0; k < DV_N; k++) dv_r[k] <= dv_nxt[k];
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_N; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k < DV_N; k++) dv_v_r[k] <= 1'b0;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= fq_vld;
      for (int k = 1; k < SQ_N; k++) sq_v_r[k] <= sq_v_r[k-1];
      rd_v_r    <= sq_v_r[SQ_N-1];
      dv_v_r[0] <= rd_v_r;
      for (int k = 1; k < DV_N; k++) dv_v_r[k] <= dv_v_r[k-1];
      out_v_r   <= dv_v_r[DV_N-1];
    end
  end

endmodule
